@@ rtl/daes_pkg.sv @@
// Shared constants and types for the damped auto-exposure step block.
// No dependencies; the top level imports this package.
package daes_pkg;

   // field widths
   localparam int LUMA_W      = 16;
   localparam int LUMA_FRAC_W = 8;
   localparam int TGT_W       = 8;
   localparam int EXP_W       = 16;
   localparam int GAIN_W      = 10;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // stream payload widths, data padded to whole bytes
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 2;

   // ratio fraction bits, default for the top-level parameter
   localparam int RATIO_FRAC_BITS_DEF = 16;

   // luma of 1.0 in Q8.8 and the 6.0 deadband in Q8.8
   localparam logic [LUMA_W-1:0] LUMA_ONE    = 16'd256;
   localparam logic [LUMA_W:0]   DEADBAND_Q8 = 17'd1536;

   // damping 1 + (r - 1) * 0.6 = (2 + 3r) / 5
   localparam int               DAMP_NUM   = 2;
   localparam int               DAMP_DEN_W = 3;
   localparam logic [DAMP_DEN_W-1:0] DAMP_DEN = 3'd5;

   // reset values of the configuration registers
   localparam logic [TGT_W-1:0]  TARGET_LUMA_RST    = 8'd110;
   localparam logic [EXP_W-1:0]  EXPOSURE_MIN_RST   = 16'd0;
   localparam logic [EXP_W-1:0]  EXPOSURE_MAX_RST   = 16'd0;
   localparam logic [GAIN_W-1:0] GAIN_MIN_RST       = 10'd0;
   localparam logic [GAIN_W-1:0] GAIN_MAX_RST       = 10'd0;
   localparam logic              GAIN_PRESENT_RST   = 1'b0;
   localparam logic [EXP_W-1:0]  EXPOSURE_START_RST = 16'd0;
   localparam logic [GAIN_W-1:0] GAIN_START_RST     = 10'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_LUMA    = 3'd0,
      CSR_EXPOSURE_MIN   = 3'd1,
      CSR_EXPOSURE_MAX   = 3'd2,
      CSR_GAIN_MIN       = 3'd3,
      CSR_GAIN_MAX       = 3'd4,
      CSR_GAIN_PRESENT   = 3'd5,
      CSR_EXPOSURE_START = 3'd6,
      CSR_GAIN_START     = 3'd7
   } csr_index_type;

endpackage

@@ rtl/daes_serial_div.sv @@
// Restoring divider, one quotient bit per cycle, MSB first.
// Generic; used for the luma ratio and for the damping divide. No dependencies.
module daes_serial_div #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

   logic [NUM_W-1:0] work_ff, work_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DEN_W:0] trial;
   logic [DEN_W:0] diff;
   logic           fits;

   // remainder stays below the divisor, so one extra bit holds the trial
   always_comb begin
      trial   = {rem_ff, work_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      fits    = trial >= {1'b0, den_ff};
      rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      work_in = {work_ff[NUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // dividend bits leave at the top while quotient bits enter at the bottom
   always_ff @(posedge clock) begin
      if (start) begin
         work_ff <= num;
         rem_ff  <= '0;
         den_ff  <= den;
      end else if (busy_ff) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
      end
   end

   assign done = done_ff;
   assign quot = work_ff;

endmodule

@@ rtl/daes_serial_mul.sv @@
// Shift-add multiplier, one multiplier bit per cycle, MSB first.
// Generic; used to scale exposure and gain. No dependencies.
module daes_serial_mul #(
   parameter int A_W = 16,
   parameter int B_W = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [A_W-1:0]       a,
   input  logic [B_W-1:0]       b,
   output logic                 done,
   output logic [A_W+B_W-1:0]   prod
);

   localparam int P_W   = A_W + B_W;
   localparam int CNT_W = $clog2(A_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(A_W - 1);

   logic [A_W-1:0] a_ff;
   logic [B_W-1:0] b_ff;
   logic [P_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff;
   logic           busy_ff;
   logic           done_ff;

   always_comb begin
      acc_in = {acc_ff[P_W-2:0], 1'b0};
      if (a_ff[A_W-1]) begin
         acc_in = acc_in + {{A_W{1'b0}}, b_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         b_ff   <= b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         a_ff   <= {a_ff[A_W-2:0], 1'b0};
         acc_ff <= acc_in;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

@@ rtl/damped_auto_exposure_step_top.sv @@
// Top level of the damped auto-exposure step: control, state and stream ports.
// Depends on daes_pkg, daes_serial_div and daes_serial_mul.
//
// Usage:
//   Write the configuration registers through csr_we/csr_index/csr_wdata while
//   the block is idle; a write of exposure_start or gain_start also loads the
//   live exposure or gain. Then send one transfer per frame on req_* carrying
//   the frame mean luma (Q8.8). Each request yields exactly one transfer on
//   rsp_* with the exposure and gain after the step and the two written flags.
//
// Processing:
//   An item in the deadband skips the datapath. Any other item runs
//   through the serial ratio divider (16 + RATIO_FRAC_BITS bit steps), the
//   serial divide by five (10 + RATIO_FRAC_BITS bit steps) and the two
//   parallel serial multipliers (16 bit steps). One item is in work at a time;
//   req_tready is high only when idle, and the next item can be accepted once
//   the result has entered the output register.
//
// Reset (synchronous, active high) restores all register defaults and clears
// exposure and gain to their start values. A stalled receiver holds the
// result in the output register; the next item may be accepted meanwhile but
// its result waits until the held one has been transferred.
module damped_auto_exposure_step_top
   import daes_pkg::*;
#(
   parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [15:0] mean_luma

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [15:0] exposure_now, [25:16] gain_now
   output logic [RSP_USER_W-1:0] rsp_tuser    // [0] exposure_written, [1] gain_written
);

   localparam int F         = RATIO_FRAC_BITS;
   localparam int RAT_NUM_W = TGT_W + LUMA_FRAC_W + F;  // target << (8 + F)
   localparam int RATIO_W   = TGT_W + F;                // ratio below 256.0
   localparam int SUM_W     = RATIO_W + 2;              // 2*ONE + 3*ratio
   localparam int PROD_W    = EXP_W + RATIO_W;
   localparam int SCL_W     = PROD_W - F;
   localparam logic [SUM_W-1:0] TWO_ONE = SUM_W'(DAMP_NUM) << F;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_RATIO = 5'b00010,
      ST_DAMP  = 5'b00100,
      ST_SCALE = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [TGT_W-1:0]  target_luma_ff;
   logic [EXP_W-1:0]  exposure_min_ff;
   logic [EXP_W-1:0]  exposure_max_ff;
   logic [GAIN_W-1:0] gain_min_ff;
   logic [GAIN_W-1:0] gain_max_ff;
   logic              gain_present_ff;

   // live sensor settings
   logic [EXP_W-1:0]  exposure_ff;
   logic [GAIN_W-1:0] gain_ff;

   logic dark_ff;     // frame too dark: raise exposure first
   logic change_ff;   // outside the deadband

   // output register
   logic              rsp_valid_ff;
   logic [EXP_W-1:0]  rsp_exp_ff;
   logic [GAIN_W-1:0] rsp_gain_ff;
   logic              rsp_exp_w_ff;
   logic              rsp_gain_w_ff;

   // request decode
   logic              req_accept;
   logic [LUMA_W-1:0] luma;
   logic [LUMA_W:0]   tgt_q8;
   logic              in_dark;
   logic              in_bright;
   logic [LUMA_W-1:0] luma_floor;

   // datapath
   logic                 ratio_start, ratio_done;
   logic [RAT_NUM_W-1:0] ratio_num, ratio_quot;
   logic [RATIO_W-1:0]   ratio;
   logic                 damp_start, damp_done;
   logic [SUM_W-1:0]     damp_sum, damp_quot;
   logic [RATIO_W-1:0]   damped;
   logic                 mul_start, exp_mul_done, gain_mul_done;
   logic [EXP_W-1:0]     gain_operand;
   logic [PROD_W-1:0]    exp_prod, gain_prod;
   logic [SCL_W-1:0]     exp_scaled, gain_scaled;

   // write-back decision
   logic              rsp_free;
   logic              commit;
   logic [EXP_W-1:0]  exp_next;
   logic [GAIN_W-1:0] gain_next;
   logic              exp_w_next;
   logic              gain_w_next;
   logic [EXP_W-1:0]  exp_clamped;
   logic [GAIN_W-1:0] gain_clamped;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign luma       = req_tdata[LUMA_W-1:0];

   // deadband test on the Q8.8 error, both sides in 17 bits
   always_comb begin
      tgt_q8     = {1'b0, target_luma_ff, {LUMA_FRAC_W{1'b0}}};
      in_dark    = ({1'b0, luma} + DEADBAND_Q8) < tgt_q8;
      in_bright  = {1'b0, luma} > (tgt_q8 + DEADBAND_Q8);
      luma_floor = (luma < LUMA_ONE) ? LUMA_ONE : luma;
   end

   // ratio = (target << (8 + F)) / max(luma, 1.0)
   assign ratio_start = req_accept && (in_dark || in_bright);
   assign ratio_num   = {target_luma_ff, {(LUMA_FRAC_W + F){1'b0}}};

   daes_serial_div #(
      .NUM_W (RAT_NUM_W),
      .DEN_W (LUMA_W)
   ) u_ratio_div (
      .clock (clock),
      .reset (reset),
      .start (ratio_start),
      .num   (ratio_num),
      .den   (luma_floor),
      .done  (ratio_done),
      .quot  (ratio_quot)
   );

   // quotient never reaches 256.0, so the upper bits are zero
   assign ratio = ratio_quot[RATIO_W-1:0];

   // damped = (2*ONE + 3*ratio) / 5
   assign damp_start = (state_ff == ST_RATIO) && ratio_done;
   assign damp_sum   = TWO_ONE + {1'b0, ratio, 1'b0} + {2'b00, ratio};

   daes_serial_div #(
      .NUM_W (SUM_W),
      .DEN_W (DAMP_DEN_W)
   ) u_damp_div (
      .clock (clock),
      .reset (reset),
      .start (damp_start),
      .num   (damp_sum),
      .den   (DAMP_DEN),
      .done  (damp_done),
      .quot  (damp_quot)
   );

   assign damped = damp_quot[RATIO_W-1:0];

   // scale exposure and gain side by side; a dark frame lifts zero gain to one
   assign mul_start = (state_ff == ST_DAMP) && damp_done;

   always_comb begin
      gain_operand = {{(EXP_W - GAIN_W){1'b0}}, gain_ff};
      if (dark_ff && (gain_ff == '0)) begin
         gain_operand = EXP_W'(1);
      end
   end

   daes_serial_mul #(
      .A_W (EXP_W),
      .B_W (RATIO_W)
   ) u_exp_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (exposure_ff),
      .b     (damped),
      .done  (exp_mul_done),
      .prod  (exp_prod)
   );

   daes_serial_mul #(
      .A_W (EXP_W),
      .B_W (RATIO_W)
   ) u_gain_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (gain_operand),
      .b     (damped),
      .done  (gain_mul_done),
      .prod  (gain_prod)
   );

   assign exp_scaled  = exp_prod[PROD_W-1:F];
   assign gain_scaled = gain_prod[PROD_W-1:F];

   // pick the lever and clamp; dark raises exposure then gain,
   // bright lowers gain then exposure
   always_comb begin
      exp_next     = exposure_ff;
      gain_next    = gain_ff;
      exp_w_next   = 1'b0;
      gain_w_next  = 1'b0;
      exp_clamped  = exposure_ff;
      gain_clamped = gain_ff;
      if (change_ff) begin
         if (dark_ff) begin
            exp_clamped = (exp_scaled > SCL_W'(exposure_max_ff)) ?
                          exposure_max_ff : exp_scaled[EXP_W-1:0];
            gain_clamped = (gain_scaled > SCL_W'(gain_max_ff)) ?
                           gain_max_ff : gain_scaled[GAIN_W-1:0];
            if (exp_clamped != exposure_ff) begin
               exp_next   = exp_clamped;
               exp_w_next = 1'b1;
            end else if (gain_present_ff && (gain_ff < gain_max_ff)) begin
               gain_next   = gain_clamped;
               gain_w_next = 1'b1;
            end
         end else begin
            exp_clamped = (exp_scaled < SCL_W'(exposure_min_ff)) ?
                          exposure_min_ff : exp_scaled[EXP_W-1:0];
            gain_clamped = (gain_scaled < SCL_W'(gain_min_ff)) ?
                           gain_min_ff : gain_scaled[GAIN_W-1:0];
            if (gain_present_ff && (gain_ff > gain_min_ff)) begin
               gain_next   = gain_clamped;
               gain_w_next = 1'b1;
            end else if (exp_clamped != exposure_ff) begin
               exp_next   = exp_clamped;
               exp_w_next = 1'b1;
            end
         end
      end
   end

   // the result may enter the output register once the held one is taken
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign commit   = (state_ff == ST_DONE) && rsp_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (in_dark || in_bright) ? ST_RATIO : ST_DONE;
            end
         end
         ST_RATIO: begin
            if (ratio_done) begin
               state_in = ST_DAMP;
            end
         end
         ST_DAMP: begin
            if (damp_done) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (exp_mul_done && gain_mul_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         dark_ff   <= 1'b0;
         change_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_accept) begin
            dark_ff   <= in_dark;
            change_ff <= in_dark || in_bright;
         end
      end
   end

   // configuration and live settings; a start write reloads the live value
   always_ff @(posedge clock) begin
      if (reset) begin
         target_luma_ff  <= TARGET_LUMA_RST;
         exposure_min_ff <= EXPOSURE_MIN_RST;
         exposure_max_ff <= EXPOSURE_MAX_RST;
         gain_min_ff     <= GAIN_MIN_RST;
         gain_max_ff     <= GAIN_MAX_RST;
         gain_present_ff <= GAIN_PRESENT_RST;
         exposure_ff     <= EXPOSURE_START_RST;
         gain_ff         <= GAIN_START_RST;
      end else begin
         if (commit) begin
            exposure_ff <= exp_next;
            gain_ff     <= gain_next;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_TARGET_LUMA:    target_luma_ff  <= csr_wdata[TGT_W-1:0];
               CSR_EXPOSURE_MIN:   exposure_min_ff <= csr_wdata[EXP_W-1:0];
               CSR_EXPOSURE_MAX:   exposure_max_ff <= csr_wdata[EXP_W-1:0];
               CSR_GAIN_MIN:       gain_min_ff     <= csr_wdata[GAIN_W-1:0];
               CSR_GAIN_MAX:       gain_max_ff     <= csr_wdata[GAIN_W-1:0];
               CSR_GAIN_PRESENT:   gain_present_ff <= csr_wdata[0];
               CSR_EXPOSURE_START: exposure_ff     <= csr_wdata[EXP_W-1:0];
               CSR_GAIN_START:     gain_ff         <= csr_wdata[GAIN_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // output register: hold until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_exp_ff    <= exp_next;
         rsp_gain_ff   <= gain_next;
         rsp_exp_w_ff  <= exp_w_next;
         rsp_gain_w_ff <= gain_w_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - EXP_W - GAIN_W){1'b0}}, rsp_gain_ff, rsp_exp_ff};
   assign rsp_tuser  = {rsp_gain_w_ff, rsp_exp_w_ff};

endmodule
